/* hw/rtl/ltgp_pkg.sv */
// ltgp_pkg: shared constants for the line tracking goal point block.
// Used by ltgp_dir_unit and line_tracking_goal_point; no dependencies.
package ltgp_pkg;

	localparam int UNIT_BITS  = 24;
	localparam int U_W        = UNIT_BITS + 2;
	localparam int LEAD_WIDTH = 31;
	localparam int LO_W       = LEAD_WIDTH + 1 + U_W - UNIT_BITS;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_END_X   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_END_Y   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LEAD    = 3'd4;

endpackage

/* hw/rtl/ltgp_dir_unit.sv */
// ltgp_dir_unit: sequencer for the line's unit direction and lead offsets.
// Bit-serial square root and two shift-subtract divider lanes. Uses ltgp_pkg.
module ltgp_dir_unit #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [COORD_WIDTH-1:0]         start_x,
	input  logic signed [COORD_WIDTH-1:0]         start_y,
	input  logic signed [COORD_WIDTH-1:0]         end_x,
	input  logic signed [COORD_WIDTH-1:0]         end_y,
	input  logic [ltgp_pkg::LEAD_WIDTH-1:0]       lead,
	output logic signed [ltgp_pkg::U_W-1:0]       ux,
	output logic signed [ltgp_pkg::U_W-1:0]       uy,
	output logic signed [ltgp_pkg::LO_W-1:0]      lead_off,
	output logic signed [ltgp_pkg::LO_W-1:0]      lead_off_y,
	output logic                                  ready
);
	import ltgp_pkg::*;

	localparam int C     = COORD_WIDTH;
	localparam int SQ_W  = 2 * C + 2;
	localparam int RT_W  = C + 1;
	localparam int RM_W  = RT_W + 2;
	localparam int R_W   = RT_W + 1;
	localparam int Q_W   = UNIT_BITS + 1;
	localparam int MX_W  = (RT_W > Q_W) ? RT_W : Q_W;
	localparam int CNT_W = $clog2(MX_W + 1);
	localparam int LP_W  = LEAD_WIDTH + 1 + U_W;

	localparam logic [3:0] ST_SETUP  = 4'd0;
	localparam logic [3:0] ST_SQUARE = 4'd1;
	localparam logic [3:0] ST_SUM    = 4'd2;
	localparam logic [3:0] ST_ROOT   = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_SIGN   = 4'd5;
	localparam logic [3:0] ST_LEAD   = 4'd6;
	localparam logic [3:0] ST_TRUNC  = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_x_q, neg_y_q;
	logic [C-1:0]            ax_q, ay_q;
	logic [2*C-1:0]          sqx_q, sqy_q;
	logic [SQ_W-1:0]         rad_q;
	logic [RM_W-1:0]         rem_q;
	logic [RT_W-1:0]         root_q;
	logic [R_W-1:0]          rx_q, ry_q;
	logic [Q_W-1:0]          qx_q, qy_q;
	logic signed [U_W-1:0]   ux_q, uy_q;
	logic signed [LP_W-1:0]  lprod_q, lprod_y_q;
	logic signed [LO_W-1:0]  lead_off_q, lead_off_y_q;

	logic signed [C:0]       dx, dy, dx_f;
	logic [C-1:0]            ax_n, ay_n;
	logic [RM_W-1:0]         rem_sh, trial, rem_n;
	logic                    rge;
	logic [R_W-1:0]          len_e;
	logic                    bx, by;
	logic [R_W-1:0]          rx_n, ry_n;
	logic [LP_W-1:0]         lbias, lbias_y;
	logic [LP_W-1:0]         lsum, lsum_y;

	always_comb begin
		dx   = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
		dy   = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
		dx_f = (dx == '0 && dy == '0) ? (C+1)'(1) : dx;
		ax_n = dx_f[C] ? C'(-dx_f) : dx_f[C-1:0];
		ay_n = dy[C] ? C'(-dy) : dy[C-1:0];

		rem_sh = {rem_q[RM_W-3:0], rad_q[SQ_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		rge    = rem_sh >= trial;
		rem_n  = rge ? rem_sh - trial : rem_sh;

		len_e = {1'b0, root_q};
		bx    = rx_q >= len_e;
		by    = ry_q >= len_e;
		rx_n  = (bx ? rx_q - len_e : rx_q) << 1;
		ry_n  = (by ? ry_q - len_e : ry_q) << 1;

		lbias   = {{(LP_W-UNIT_BITS){1'b0}}, {UNIT_BITS{lprod_q[LP_W-1]}}};
		lsum    = lprod_q + lbias;
		lbias_y = {{(LP_W-UNIT_BITS){1'b0}}, {UNIT_BITS{lprod_y_q[LP_W-1]}}};
		lsum_y  = lprod_y_q + lbias_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SETUP;
			cnt_q   <= '0;
		end else if (start) begin
			state_q <= ST_SETUP;
		end else begin
			unique case (state_q)
				ST_SETUP: begin
					neg_x_q <= dx_f[C];
					neg_y_q <= dy[C];
					ax_q    <= ax_n;
					ay_q    <= ay_n;
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					sqx_q   <= ax_q * ax_q;
					sqy_q   <= ay_q * ay_q;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					rad_q   <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= CNT_W'(RT_W - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					rad_q  <= rad_q << 2;
					rem_q  <= rem_n;
					root_q <= {root_q[RT_W-2:0], rge};
					if (cnt_q == '0) begin
						rx_q    <= R_W'(ax_q);
						ry_q    <= R_W'(ay_q);
						qx_q    <= '0;
						qy_q    <= '0;
						cnt_q   <= CNT_W'(Q_W - 1);
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DIV: begin
					rx_q <= rx_n;
					ry_q <= ry_n;
					qx_q <= {qx_q[Q_W-2:0], bx};
					qy_q <= {qy_q[Q_W-2:0], by};
					if (cnt_q == '0)
						state_q <= ST_SIGN;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				ST_SIGN: begin
					ux_q    <= neg_x_q ? -$signed(U_W'(qx_q)) : $signed(U_W'(qx_q));
					uy_q    <= neg_y_q ? -$signed(U_W'(qy_q)) : $signed(U_W'(qy_q));
					state_q <= ST_LEAD;
				end
				ST_LEAD: begin
					lprod_q   <= $signed({1'b0, lead}) * ux_q;
					lprod_y_q <= $signed({1'b0, lead}) * uy_q;
					state_q   <= ST_TRUNC;
				end
				ST_TRUNC: begin
					lead_off_q   <= lsum[LP_W-1:UNIT_BITS];
					lead_off_y_q <= lsum_y[LP_W-1:UNIT_BITS];
					state_q      <= ST_DONE;
				end
				ST_DONE: state_q <= ST_DONE;
				default: state_q <= ST_SETUP;
			endcase
		end
	end

	assign ux         = ux_q;
	assign uy         = uy_q;
	assign lead_off   = lead_off_q;
	assign lead_off_y = lead_off_y_q;
	assign ready      = (state_q == ST_DONE);

endmodule

/* hw/rtl/line_tracking_goal_point.sv */
// line_tracking_goal_point: carrot-chasing goal point on a configured line.
// One transaction per cycle through a 7-stage pipeline, while m_tready is high and the direction unit is ready.
// Direction unit recomputes after reset and after each register write, through the
// serial root and divider; s_tready stays low meanwhile. Registers reset to zero
// points and 1.0 m lead.
module line_tracking_goal_point #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 8,
	localparam int CFG_W = (COORD_WIDTH > ltgp_pkg::LEAD_WIDTH) ? COORD_WIDTH
		: ltgp_pkg::LEAD_WIDTH,
	localparam int IO_W  = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ltgp_pkg::REG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]                 cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [IO_W-1:0]                  s_tdata,   // vehicle_x, vehicle_y
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [IO_W-1:0]                  m_tdata,   // goal_x, goal_y
	output logic [0:0]                       m_tuser    // steer_mode
);
	import ltgp_pkg::*;

	localparam int C     = COORD_WIDTH;
	localparam int LW    = LEAD_WIDTH;
	localparam int DF_W  = C + 1;
	localparam int PR_W  = DF_W + U_W;
	localparam int SM_W  = PR_W + 1;
	localparam int E_W   = SM_W - UNIT_BITS;
	localparam int EP_W  = E_W + U_W;
	localparam int PX_W  = EP_W - UNIT_BITS + 1;
	localparam int CMP_W = (E_W > LW + 2) ? E_W : LW + 2;
	localparam int G_W   = ((PX_W > LO_W) ? PX_W : LO_W) + 1;
	localparam logic [LW-1:0] MIN_LEAD = LW'(1) << FRAC_BITS;
	localparam logic signed [G_W-1:0] G_MAX = (G_W'(1) <<< (C - 1)) - G_W'(1);
	localparam logic signed [G_W-1:0] G_MIN = -G_MAX - G_W'(1);

	logic signed [C-1:0]   start_x_q, start_y_q, end_x_q, end_y_q;
	logic [LW-1:0]         lead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			lead_q    <= MIN_LEAD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_X: start_x_q <= cfg_wdata[C-1:0];
				REG_START_Y: start_y_q <= cfg_wdata[C-1:0];
				REG_END_X:   end_x_q   <= cfg_wdata[C-1:0];
				REG_END_Y:   end_y_q   <= cfg_wdata[C-1:0];
				REG_LEAD:    lead_q    <= (cfg_wdata[LW-1:0] < MIN_LEAD) ? MIN_LEAD
					: cfg_wdata[LW-1:0];
				default: ;
			endcase
		end
	end

	logic signed [U_W-1:0]  ux, uy;
	logic signed [LO_W-1:0] lead_off, lead_off_y;
	logic                   unit_ready;

	ltgp_dir_unit #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dir (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_we),
		.start_x   (start_x_q),
		.start_y   (start_y_q),
		.end_x     (end_x_q),
		.end_y     (end_y_q),
		.lead      (lead_q),
		.ux        (ux),
		.uy        (uy),
		.lead_off  (lead_off),
		.lead_off_y(lead_off_y),
		.ready     (unit_ready)
	);

	logic adv, in_acc;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [DF_W-1:0] dfx_s1, dfy_s1;
	logic signed [PR_W-1:0] prx_s2, pry_s2;
	logic signed [SM_W-1:0] sum_s3;
	logic signed [E_W-1:0]  e_s4;
	logic signed [EP_W-1:0] epx_s5, epy_s5;
	logic                   mode_s5, mode_s6, mode_s7;
	logic signed [PX_W-1:0] px_s6, py_s6;
	logic signed [C-1:0]    gx_s7, gy_s7;

	logic signed [C-1:0]    vx, vy;
	logic [SM_W-1:0]        sum_b;
	logic [EP_W-1:0]        epx_b, epy_b;
	logic signed [PX_W-1:0] tx, ty;
	logic signed [G_W-1:0]  gtx, gty, gax, gay, gx, gy, sgx, sgy;

	assign adv      = !vld_s7 || m_tready;
	assign s_tready = adv && unit_ready;
	assign in_acc   = s_tvalid && s_tready;
	assign vx       = s_tdata[C-1:0];
	assign vy       = s_tdata[2*C-1:C];

	always_comb begin
		sum_b = sum_s3 + {{(SM_W-UNIT_BITS){1'b0}}, {UNIT_BITS{sum_s3[SM_W-1]}}};
		epx_b = epx_s5 + {{(EP_W-UNIT_BITS){1'b0}}, {UNIT_BITS{epx_s5[EP_W-1]}}};
		epy_b = epy_s5 + {{(EP_W-UNIT_BITS){1'b0}}, {UNIT_BITS{epy_s5[EP_W-1]}}};
		tx    = PX_W'($signed(epx_b[EP_W-1:UNIT_BITS]));
		ty    = PX_W'($signed(epy_b[EP_W-1:UNIT_BITS]));
		gtx   = G_W'(px_s6) + G_W'(lead_off);
		gty   = G_W'(py_s6) + G_W'(lead_off_y);
		gax   = G_W'(px_s6) + G_W'(end_x_q);
		gay   = G_W'(py_s6) + G_W'(end_y_q);
		gx    = mode_s6 ? gtx : ($signed(gax + G_W'(gax[G_W-1])) >>> 1);
		gy    = mode_s6 ? gty : ($signed(gay + G_W'(gay[G_W-1])) >>> 1);
		sgx   = (gx > G_MAX) ? G_MAX : ((gx < G_MIN) ? G_MIN : gx);
		sgy   = (gy > G_MAX) ? G_MAX : ((gy < G_MIN) ? G_MIN : gy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dfx_s1  <= $signed({end_x_q[C-1], end_x_q}) - $signed({vx[C-1], vx});
			dfy_s1  <= $signed({end_y_q[C-1], end_y_q}) - $signed({vy[C-1], vy});
			prx_s2  <= dfx_s1 * ux;
			pry_s2  <= dfy_s1 * uy;
			sum_s3  <= SM_W'(prx_s2) + SM_W'(pry_s2);
			e_s4    <= sum_b[SM_W-1:UNIT_BITS];
			epx_s5  <= e_s4 * ux;
			epy_s5  <= e_s4 * uy;
			mode_s5 <= $signed(CMP_W'(e_s4)) > $signed(CMP_W'({1'b0, lead_q, 1'b0}));
			px_s6   <= PX_W'(end_x_q) - tx;
			py_s6   <= PX_W'(end_y_q) - ty;
			mode_s6 <= mode_s5;
			gx_s7   <= sgx[C-1:0];
			gy_s7   <= sgy[C-1:0];
			mode_s7 <= mode_s6;
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = IO_W'({gy_s7, gx_s7});
	assign m_tuser  = mode_s7;

	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser));
	a_busy_no_accept : assert property (@(posedge clk) disable iff (!arst_n)
		!unit_ready |-> !s_tready);
	a_valid_known : assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(m_tvalid));

endmodule

/* sim/tb_line_tracking_goal_point.sv */
// tb_line_tracking_goal_point: self-checking bench for the line tracking goal point block.
// Predicts each goal from its own copy of the registers; depends on ltgp_pkg and the RTL.
module tb_line_tracking_goal_point;
	import ltgp_pkg::*;

	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam longint LEAD_MIN  = 64'sd256;
	localparam int     WDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] gx;
		logic [31:0] gy;
		logic        mode;
	} goal_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr = '0;
	logic [31:0]          cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [63:0]          m_tdata;
	logic [0:0]           m_tuser;

	line_tracking_goal_point dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	longint line_sx, line_sy, line_ex, line_ey, lead_dist;
	goal_t  pending_goals[$];
	int     mismatches = 0;
	int     idle_pct = 0;
	int     stall_pct = 0;
	int     hold_cnt = 0;
	bit     hold_req = 1'b0;
	bit     hold_seen = 1'b0;
	int     quiet_cycles = 0;

	function automatic goal_t predict_goal(logic [31:0] vx_raw, logic [31:0] vy_raw);
		longint     vx, vy, dx, dy, len, ux, uy, e, px, py, gx, gy;
		logic [65:0] ax, ay, sq, rem, root, trial;
		goal_t      g;
		vx = longint'($signed(vx_raw));
		vy = longint'($signed(vy_raw));
		dx = line_ex - line_sx;
		dy = line_ey - line_sy;
		if (dx == 0 && dy == 0) begin
			dx = 1;
			dy = 0;
		end
		ax = 66'(dx < 0 ? -dx : dx);
		ay = 66'(dy < 0 ? -dy : dy);
		sq = ax * ax + ay * ay;
		rem = '0;
		root = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | ((sq >> (2 * i)) & 66'd3);
			root = root << 1;
			trial = (root << 1) | 66'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = root | 66'd1;
			end
		end
		len = longint'(root);
		if (len < 1)
			len = 1;
		ux = (dx * 64'sd16777216) / len;
		uy = (dy * 64'sd16777216) / len;
		e = ((line_ex - vx) * ux + (line_ey - vy) * uy) / 64'sd16777216;
		px = line_ex - (e * ux) / 64'sd16777216;
		py = line_ey - (e * uy) / 64'sd16777216;
		if (e > 2 * lead_dist) begin
			g.mode = 1'b1;
			gx = px + (lead_dist * ux) / 64'sd16777216;
			gy = py + (lead_dist * uy) / 64'sd16777216;
		end else begin
			g.mode = 1'b0;
			gx = (px + line_ex) / 2;
			gy = (py + line_ey) / 2;
		end
		gx = gx > COORD_MAX ? COORD_MAX : (gx < COORD_MIN ? COORD_MIN : gx);
		gy = gy > COORD_MAX ? COORD_MAX : (gy < COORD_MIN ? COORD_MIN : gy);
		g.gx = gx[31:0];
		g.gy = gy[31:0];
		return g;
	endfunction

	// receiver: random stalls plus a long counted hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt  <= 400;
			m_tready  <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		goal_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0]};
			if (pending_goals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: goal %h %h mode %b",
						got.gx, got.gy, got.mode);
			end else begin
				want = pending_goals.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h mode %b, got %h %h mode %b",
							want.gx, want.gy, want.mode, got.gx, got.gy, got.mode);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_vehicle(logic [31:0] vx, logic [31:0] vy);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {vy, vx};
		do
			@(posedge clk);
		while (!s_tready);
		pending_goals.push_back(predict_goal(vx, vy));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_goals.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		longint v;
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_START_X: line_sx = longint'($signed(val));
			REG_START_Y: line_sy = longint'($signed(val));
			REG_END_X:   line_ex = longint'($signed(val));
			REG_END_Y:   line_ey = longint'($signed(val));
			REG_LEAD: begin
				v = longint'(val[30:0]);
				lead_dist = v < LEAD_MIN ? LEAD_MIN : v;
			end
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_line(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
			logic [31:0] ey, logic [31:0] lead);
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
		write_reg(REG_LEAD, lead);
		end_writes();
	endtask

	function automatic logic [31:0] near_coord(logic [31:0] base);
		case ($urandom_range(3))
			0: return $urandom;
			1: return base + 32'($urandom_range(8191)) - 32'd4096;
			2: return base + 32'($urandom_range(1 << 20)) - 32'd524288;
			default: return base ^ (32'd1 << $urandom_range(31));
		endcase
	endfunction

	task automatic test_directed();
		// equal points at reset: direction falls back to +x
		send_vehicle(32'h0000_0000, 32'h0000_0000);
		send_vehicle(32'h8000_0000, 32'h8000_0000);
		send_vehicle(32'h7fff_ffff, 32'h7fff_ffff);
		send_vehicle(32'h8000_0000, 32'h7fff_ffff);
		send_vehicle(32'hffff_f000, 32'h0000_0100);
		drain();
		// diagonal line of modest length, lead below minimum
		set_line(32'd0, 32'd0, 32'd25600, 32'd12800, 32'd10);
		send_vehicle(32'd0, 32'd0);
		send_vehicle(32'd25600, 32'd12800);
		send_vehicle(32'd25500, 32'd12750);
		send_vehicle(32'd40000, 32'd40000);
		send_vehicle(-32'sd20000, 32'd3000);
		send_vehicle(32'h8000_0000, 32'h8000_0000);
		send_vehicle(32'h7fff_ffff, 32'h8000_0000);
		drain();
		// unused register indices must leave the line alone
		write_reg(3'd5, 32'hdead_beef);
		write_reg(3'd6, 32'h1234_5678);
		write_reg(3'd7, 32'hffff_ffff);
		end_writes();
		// extreme end points, lead written with its top bit set
		set_line(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_vehicle(32'h8000_0000, 32'h8000_0000);
		send_vehicle(32'h7fff_ffff, 32'h7fff_ffff);
		send_vehicle(32'h0000_0000, 32'h7fff_ffff);
		send_vehicle(32'h7fff_ffff, 32'h8000_0000);
		drain();
		set_line(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vehicle(32'h7fff_ffff, 32'h8000_0000);
		send_vehicle(32'h0000_0000, 32'h0000_0000);
		send_vehicle(32'h8000_0000, 32'h7fff_ffff);
		drain();
	endtask

	task automatic test_random_lines(int lines, int per_line);
		logic [31:0] sx, sy, ex, ey, lead, bx, by;
		for (int l = 0; l < lines; l++) begin
			sx = $urandom;
			sy = $urandom;
			case ($urandom_range(3))
				0: begin ex = $urandom; ey = $urandom; end
				1: begin
					ex = sx + 32'($urandom_range(65535)) - 32'd32768;
					ey = sy + 32'($urandom_range(65535)) - 32'd32768;
				end
				2: begin ex = sx; ey = sy; end
				default: begin ex = sx + 32'($urandom_range(3)); ey = sy; end
			endcase
			lead = $urandom_range(1) ? 32'($urandom_range(4096)) : $urandom;
			set_line(sx, sy, ex, ey, lead);
			for (int i = 0; i < per_line; i++) begin
				bx = $urandom_range(1) ? sx : ex;
				by = $urandom_range(1) ? sy : ey;
				send_vehicle(near_coord(bx), near_coord(by));
			end
			drain();
		end
	endtask

	task automatic test_backpressure();
		hold_req <= ~hold_req;
		for (int i = 0; i < 40; i++)
			send_vehicle($urandom, $urandom);
		drain();
	endtask

	initial begin
		line_sx = 0;
		line_sy = 0;
		line_ex = 0;
		line_ey = 0;
		lead_dist = LEAD_MIN;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_pct = 0;  stall_pct = 0;  test_random_lines(5, 60);
		idle_pct = 61; stall_pct = 0;  test_random_lines(5, 60);
		idle_pct = 0;  stall_pct = 61; test_random_lines(5, 60);
		idle_pct = 24; stall_pct = 24; test_random_lines(5, 60);
		idle_pct = 0;  stall_pct = 0;  test_backpressure();
		drain();
		if (mismatches == 0 && pending_goals.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
